@@ sv/tgf_pkg.sv @@
// Package for the temperature glitch filter: sample and row types, reset constants
// and the raw-reading conversion. It depends on nothing.
package tgf_pkg;

  localparam int SENSOR_COUNT_DEF = 8;
  localparam int HIST_DEPTH       = 4;
  localparam int IDX_W            = 3;
  localparam int RAW_W            = 16;
  localparam int SAMPLE_W         = 19;
  localparam int DIST_W           = 19;
  localparam int PROD_W           = 21;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [DIST_W-1:0]   dist_t;

  localparam sample_t HIST_RESET = sample_t'(15000);
  localparam sample_t CUR_RESET  = sample_t'(0);

  // One memory word per sensor: filtered value and history, newest in slot 0.
  typedef struct packed {
    sample_t                  cur;
    sample_t [HIST_DEPTH-1:0] hist;
  } row_t;

  // floor((raw*25 + 2) / 4): shift-add multiply, then an arithmetic shift.
  function automatic sample_t convert_raw(input logic signed [RAW_W-1:0] raw);
    logic signed [PROD_W-1:0] ext;
    logic signed [PROD_W-1:0] num;
    ext = PROD_W'(raw);
    num = (ext <<< 4) + (ext <<< 3) + ext + PROD_W'(2);
    return num[PROD_W-1:2];
  endfunction

  function automatic row_t reset_row();
    row_t r;
    r.cur = CUR_RESET;
    for (int k = 0; k < HIST_DEPTH; k++) r.hist[k] = HIST_RESET;
    return r;
  endfunction

endpackage

@@ sv/temperature_glitch_filter_top.sv @@
// Temperature glitch filter top level: per-sensor row memory with a read-modify-write
// pipeline and an output register. Depends on tgf_pkg.
// An accepted request passes the update stage, then the output register; one request per
// cycle unless the output stalls; a request to the row just written has it forwarded.
// Reset: synchronous, active low; clears pipeline valids and per-row valid bits, so every
// row reads as history 15000 and filtered value 0 until written.
module temperature_glitch_filter_top #(
  parameter int SENSOR_COUNT = tgf_pkg::SENSOR_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tgf_pkg::IDX_W-1:0]           in_sensor_index,
  input  logic signed [tgf_pkg::RAW_W-1:0]    in_raw_reading,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tgf_pkg::IDX_W-1:0]           out_sensor_echo,
  output logic signed [tgf_pkg::SAMPLE_W-1:0] out_new_sample,
  output logic signed [tgf_pkg::SAMPLE_W-1:0] out_filtered_value
);

  localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int EW = (AW > tgf_pkg::IDX_W) ? AW : tgf_pkg::IDX_W;
  localparam int HD = tgf_pkg::HIST_DEPTH;

  // Sensor row memory and its per-row valid bits.
  tgf_pkg::row_t mem [SENSOR_COUNT];
  tgf_pkg::row_t mem_q_r;
  logic [SENSOR_COUNT-1:0] vld_r;

  // Update stage registers.
  logic                         s1_v_r;
  logic                         s1_in_range_r;
  logic [tgf_pkg::IDX_W-1:0]    s1_idx_r;
  logic [AW-1:0]                s1_addr_r;
  tgf_pkg::sample_t             s1_sample_r;
  logic                         s1_row_vld_r;
  logic                         fwd_r;
  tgf_pkg::row_t                fwd_row_r;

  // Output register.
  logic                         out_v_r;
  logic [tgf_pkg::IDX_W-1:0]    out_idx_r;
  tgf_pkg::sample_t             out_sample_r;
  tgf_pkg::sample_t             out_filt_r;

  logic                         in_fire;
  logic                         s1_adv;
  logic                         wr_en;
  logic [EW-1:0]                idx_ext;
  logic [AW-1:0]                in_addr;
  logic                         in_range;
  tgf_pkg::row_t                old_row;
  tgf_pkg::row_t                new_row;
  tgf_pkg::sample_t             old_cur;
  tgf_pkg::sample_t             filt;
  tgf_pkg::dist_t [HD-1:0]      span;
  logic [HD-1:0]                least;
  logic signed [tgf_pkg::SAMPLE_W:0] diff [HD];

  // Handshake: the update stage advances whenever the output register frees up.
  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = s1_v_r && s1_adv && s1_in_range_r;

  assign idx_ext  = EW'(in_sensor_index);
  assign in_addr  = idx_ext[AW-1:0];
  assign in_range = (32'(in_sensor_index) < SENSOR_COUNT);

  // Read port: registered read on request acceptance; write port from the
  // update stage as it hands its result on.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_q_r <= mem[in_addr];
    end
    if (wr_en) begin
      mem[s1_addr_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[s1_addr_r] <= 1'b1;
    end
  end

  // Accept into the update stage; capture the forwarded row when the item
  // ahead writes the same sensor at this very edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
      fwd_r  <= in_valid && wr_en && (s1_addr_r == in_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_in_range_r <= in_range;
      s1_idx_r      <= in_sensor_index;
      s1_addr_r     <= in_addr;
      s1_sample_r   <= tgf_pkg::convert_raw(in_raw_reading);
      s1_row_vld_r  <= vld_r[in_addr];
      fwd_row_r     <= new_row;
    end
  end

  // Pick the row the item sees: forwarded, stored, or reset contents.
  always_comb begin
    if (fwd_r) begin
      old_row = fwd_row_r;
    end else if (s1_row_vld_r) begin
      old_row = mem_q_r;
    end else begin
      old_row = tgf_pkg::reset_row();
    end
  end

  // Shift the new sample in, then take the newest of the closest entries that
  // is above zero; if there is none, the old filtered value holds.
  always_comb begin
    old_cur         = old_row.cur;
    new_row.hist[0] = s1_sample_r;
    for (int k = 1; k < HD; k++) begin
      new_row.hist[k] = old_row.hist[k-1];
    end
    for (int k = 0; k < HD; k++) begin
      diff[k] = (tgf_pkg::SAMPLE_W+1)'(new_row.hist[k])
              - (tgf_pkg::SAMPLE_W+1)'(old_cur);
      span[k] = diff[k][tgf_pkg::SAMPLE_W] ? tgf_pkg::DIST_W'(-diff[k])
                                           : tgf_pkg::DIST_W'(diff[k]);
    end
    for (int k = 0; k < HD; k++) begin
      least[k] = 1'b1;
      for (int j = 0; j < HD; j++) begin
        if (span[k] > span[j]) least[k] = 1'b0;
      end
    end
    filt = old_cur;
    for (int k = HD - 1; k >= 0; k--) begin
      if (least[k] && (new_row.hist[k] > 0)) filt = new_row.hist[k];
    end
    new_row.cur = filt;
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_adv) begin
      out_idx_r    <= s1_idx_r;
      out_sample_r <= s1_sample_r;
      out_filt_r   <= s1_in_range_r ? filt : tgf_pkg::sample_t'(0);
    end
  end

  assign out_valid          = out_v_r;
  assign out_sensor_echo    = out_idx_r;
  assign out_new_sample     = out_sample_r;
  assign out_filtered_value = out_filt_r;

  // Every accepted request occupies the update stage next cycle.
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_v_r) else $error("accepted request lost before update stage");

  // Forwarding only ever serves an item that is actually present.
  a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_v_r) else $error("forward flag without an item");

  // An item in the update stage is written back only while in range.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(s1_addr_r) < SENSOR_COUNT) && s1_in_range_r)
    else $error("row write for a sensor beyond the count");

endmodule

@@ tb/temperature_glitch_filter_top_tb.sv @@
// Self-checking testbench for temperature_glitch_filter_top: converts and filters
// readings in its own model and checks every result in order.
// Depends on tgf_pkg and the temperature_glitch_filter_top RTL.
module temperature_glitch_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SENSORS       = tgf_pkg::SENSOR_COUNT_DEF;
  localparam int IDX_W         = tgf_pkg::IDX_W;
  localparam int RAW_W         = tgf_pkg::RAW_W;
  localparam int HIST_DEPTH    = tgf_pkg::HIST_DEPTH;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 8;

  // One result as the filter reports it.
  typedef struct packed {
    logic [IDX_W-1:0] sensor;
    tgf_pkg::sample_t sample;
    tgf_pkg::sample_t filtered;
  } reading_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [IDX_W-1:0]        in_sensor_index;
  logic signed [RAW_W-1:0] in_raw_reading;
  logic                    out_valid;
  logic                    out_ready;
  logic [IDX_W-1:0]        out_sensor_echo;
  tgf_pkg::sample_t        out_new_sample;
  tgf_pkg::sample_t        out_filtered_value;

  // Model state: per-sensor sample trail (newest in slot 0) and held filtered value.
  tgf_pkg::sample_t trail [SENSORS][HIST_DEPTH];
  tgf_pkg::sample_t held  [SENSORS];

  reading_result_t awaited_results[$];

  int errors    = 0;
  int cycles    = 0;
  int gap_pct   = 25;   // chance in a hundred that the sender idles a cycle
  int stall_pct = 25;   // chance in a hundred that the receiver stalls a cycle
  int ambient   = 2400; // raw level that the near-ambient readings cluster round

  temperature_glitch_filter_top #(
    .SENSOR_COUNT(SENSORS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sensor_index   (in_sensor_index),
    .in_raw_reading    (in_raw_reading),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sensor_echo   (out_sensor_echo),
    .out_new_sample    (out_new_sample),
    .out_filtered_value(out_filtered_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Raw word (1/16 degree) to hundredths, rounded half up: floor((raw*25 + 2) / 4).
  // An arithmetic shift of a signed int floors towards minus infinity.
  function automatic tgf_pkg::sample_t to_hundredths(input logic signed [RAW_W-1:0] raw);
    int scaled;
    scaled = int'(raw) * 25 + 2;
    return tgf_pkg::sample_t'(scaled >>> 2);
  endfunction

  // Advance the model by one accepted request and return the result it must cause.
  function automatic reading_result_t filter_reading(input logic [IDX_W-1:0] sensor,
                                                     input logic signed [RAW_W-1:0] raw);
    reading_result_t r;
    int              span [HIST_DEPTH];
    bit              least;
    bit              found;
    r.sensor   = sensor;
    r.sample   = to_hundredths(raw);
    r.filtered = '0;
    if (sensor < SENSORS) begin
      // Shift the trail, dropping the oldest sample.
      for (int k = HIST_DEPTH - 1; k > 0; k--) trail[sensor][k] = trail[sensor][k-1];
      trail[sensor][0] = r.sample;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        span[k] = int'(trail[sensor][k]) - int'(held[sensor]);
        if (span[k] < 0) span[k] = -span[k];
      end
      // Take the newest entry that is among the closest and above zero; else hold.
      r.filtered = held[sensor];
      found      = 1'b0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        least = 1'b1;
        for (int j = 0; j < HIST_DEPTH; j++)
          if (span[k] > span[j]) least = 1'b0;
        if (!found && least && trail[sensor][k] > 0) begin
          r.filtered = trail[sensor][k];
          found      = 1'b1;
        end
      end
      held[sensor] = r.filtered;
    end
    return r;
  endfunction

  // Predict on every accepted request, then check every accepted result
  // against the oldest prediction. Predicting first keeps order safe.
  always @(posedge clk) begin
    reading_result_t want;
    if (rst_n && in_valid && in_ready)
      awaited_results.push_back(filter_reading(in_sensor_index, in_raw_reading));
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result for sensor %0d with no request outstanding", out_sensor_echo);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_sensor_echo !== want.sensor) begin
          $error("sensor_echo: expected %0d, got %0d", want.sensor, out_sensor_echo);
          errors++;
        end
        if (out_new_sample !== want.sample) begin
          $error("new_sample: expected %0d, got %0d", want.sample, out_new_sample);
          errors++;
        end
        if (out_filtered_value !== want.filtered) begin
          $error("filtered_value: expected %0d, got %0d", want.filtered, out_filtered_value);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure: stall at random, as often as stall_pct says.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: abandon the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("temperature_glitch_filter_top_tb: done, errors");
      $finish;
    end
  end

  // Offer one request and hold it until accepted. Valid stays high on return,
  // so a following request goes out back to back without a glitch on valid.
  task automatic send_reading(input logic [IDX_W-1:0] sensor,
                              input logic signed [RAW_W-1:0] raw);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sensor_index <= sensor;
    in_raw_reading  <= raw;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every outstanding request has its result.
  // The first edge lets the predictor log the last request before the count is read.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Random raw word: full range, clusters near ambient and near zero (where the
  // above-zero rule bites), the extremes, and small positive readings.
  function automatic logic signed [RAW_W-1:0] pick_raw();
    case ($urandom_range(9))
      0, 1, 2: return RAW_W'($urandom_range(65535));
      3, 4, 5: return RAW_W'(ambient + int'($urandom_range(80)) - 40);
      6, 7:    return RAW_W'(int'($urandom_range(80)) - 40);
      8: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh8001;
          default: return 16'sh7ffe;
        endcase
      end
      default: return RAW_W'($urandom_range(64, 1));
    endcase
  endfunction

  // Raw-word extremes, values near zero, alternating bit patterns; first and last sensor.
  task automatic test_conversion_extremes();
    logic signed [RAW_W-1:0] corner_raws [10];
    corner_raws = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1,
                    16'sd2, -16'sd2, 16'sh5555, 16'shaaaa, 16'sh8001};
    for (int i = 0; i < 10; i++)
      send_reading((i % 2) ? IDX_W'(SENSORS - 1) : '0, corner_raws[i]);
  endtask

  // Sensor 2: newest not closest, then a tie among equally close entries where
  // the newest must win. Sensor 5: closest entries at or below zero are passed
  // over and the value holds, until the newest is closest but negative and an
  // older equally close positive entry is taken.
  task automatic test_filter_rules();
    logic signed [RAW_W-1:0] tie_raws  [5];
    logic signed [RAW_W-1:0] sign_raws [5];
    tie_raws  = '{16'sd2400, 16'sd2432, 16'sd2368, 16'sd2432, 16'sd2368};
    sign_raws = '{-16'sd8, 16'sd16, -16'sd24, -16'sd24, -16'sd16};
    foreach (tie_raws[i])  send_reading(IDX_W'(2), tie_raws[i]);
    foreach (sign_raws[i]) send_reading(IDX_W'(5), sign_raws[i]);
  endtask

  // Mixed requests over all sensors, letting the ambient level wander now and then.
  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(49) == 0) ambient = int'($urandom_range(8000)) - 2000;
      send_reading(IDX_W'($urandom_range(SENSORS - 1)), pick_raw());
    end
  endtask

  // Same traffic with no idling on either side, to keep the pipeline full.
  task automatic test_calm_stretch(input int count);
    gap_pct   = 0;
    stall_pct = 0;
    test_random_traffic(count);
    gap_pct   = 25;
    stall_pct = 25;
  endtask

  // Runs of requests to one sensor, so updates to a row follow each other closely.
  task automatic test_sensor_bursts(input int count);
    logic [IDX_W-1:0] sensor;
    int               run;
    int               sent;
    sent = 0;
    while (sent < count) begin
      sensor = IDX_W'($urandom_range(SENSORS - 1));
      run    = $urandom_range(8, 1);
      for (int i = 0; i < run && sent < count; i++) begin
        send_reading(sensor, pick_raw());
        sent++;
      end
    end
  endtask

  // Send in batches and hold the sender back until each batch has fully drained.
  task automatic test_drain_pause(input int batches, input int per_batch);
    for (int b = 0; b < batches; b++) begin
      test_random_traffic(per_batch);
      wait_for_results();
    end
  endtask

  initial begin
    in_valid        <= 1'b0;
    in_sensor_index <= '0;
    in_raw_reading  <= '0;
    out_ready       <= 1'b0;
    rst_n           <= 1'b0;
    for (int s = 0; s < SENSORS; s++) begin
      held[s] = tgf_pkg::CUR_RESET;
      for (int k = 0; k < HIST_DEPTH; k++) trail[s][k] = tgf_pkg::HIST_RESET;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_conversion_extremes();
    test_filter_rules();
    test_random_traffic(800);
    test_calm_stretch(250);
    test_sensor_bursts(300);
    test_drain_pause(5, 40);

    // Drain, then let any stray result show before the verdict.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("temperature_glitch_filter_top_tb: done, clean");
    end else begin
      $display("temperature_glitch_filter_top_tb: done, errors");
    end
    $finish;
  end

endmodule
